>>> rtl/fpd_pkg.sv
// shared types and constants of the framed packet deframer
package fpd_pkg;

  // frame delimiter bytes
  localparam logic [7:0] HDR0 = 8'h25;  // '%'
  localparam logic [7:0] HDR1 = 8'h26;  // '&'
  localparam logic [7:0] FTR0 = 8'h5E;  // '^'

  // fixed field widths
  localparam int POS_W = 6;
  localparam int CNT_W = 32;

  // frame bytes through the first footer byte, payload not counted: the four leading bytes and '^'
  localparam logic [8:0] FRAME_OVERHEAD = 9'd5;

  // parse states
  typedef enum logic [3:0] {
    S_HDR0 = 4'b0001,
    S_HDR1 = 4'b0010,
    S_BODY = 4'b0100,
    S_FTR1 = 4'b1000
  } parse_state_t;

  // what the parser does with the byte on its input
  typedef struct packed {
    logic             emit;     // byte causes a result
    logic             ok;       // good frame completes
    logic             fail;     // failure notice
    logic             wr_en;    // payload byte goes to the store
    logic [POS_W-1:0] wr_idx;
    logic [7:0]       wr_data;
  } parse_evt_t;

endpackage

>>> rtl/fpd_parser.sv
// byte parser of the deframer: frame state, checksum, size and counters
module fpd_parser #(
  parameter int PAYLOAD_BYTES   = 32,
  parameter int MAX_FRAME_BYTES = 61
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  logic [7:0]                rx_byte,
  output fpd_pkg::parse_evt_t       evt,
  output logic [fpd_pkg::CNT_W-1:0] good_next,
  output logic [fpd_pkg::CNT_W-1:0] bad_next
);
  import fpd_pkg::*;

  parse_state_t     state, state_next;
  logic [POS_W-1:0] byte_count, byte_count_next;
  logic [7:0]       frame_checksum, frame_checksum_next;
  logic [7:0]       frame_size, frame_size_next;
  logic [7:0]       running_xor, running_xor_next;
  logic             failure_latched, failure_latched_next;
  logic [CNT_W-1:0] good_count, bad_count;

  logic [7:0] pos8;
  logic [7:0] size_eff;
  logic [7:0] pay_off;
  logic       end_hit;
  logic       fail;
  logic       ok;

  assign pos8    = {2'b00, byte_count};
  assign pay_off = pos8 - 8'd4;

  // next-state logic for one byte
  always_comb begin
    state_next           = state;
    byte_count_next      = byte_count;
    frame_checksum_next  = frame_checksum;
    frame_size_next      = frame_size;
    running_xor_next     = running_xor;
    failure_latched_next = failure_latched;
    fail                 = 1'b0;
    ok                   = 1'b0;
    evt.wr_en            = 1'b0;
    evt.wr_idx           = pay_off[POS_W-1:0];
    evt.wr_data          = rx_byte;
    size_eff             = frame_size;
    end_hit              = 1'b0;
    case (state)
      S_HDR0: begin
        if (rx_byte == HDR0) begin
          state_next       = S_HDR1;
          byte_count_next  = POS_W'(1);
          running_xor_next = 8'd0;
        end else begin
          byte_count_next = '0;
          fail            = !failure_latched;
        end
      end
      S_HDR1: begin
        if (rx_byte == HDR1) begin
          state_next      = S_BODY;
          byte_count_next = POS_W'(2);
        end else if (rx_byte != HDR0) begin
          state_next      = S_HDR0;
          byte_count_next = '0;
          fail            = !failure_latched;
        end
      end
      S_BODY: begin
        byte_count_next = byte_count + POS_W'(1);
        if (byte_count == POS_W'(2)) begin
          frame_checksum_next = rx_byte;
        end else if (byte_count == POS_W'(3)) begin
          frame_size_next = rx_byte;
          size_eff        = rx_byte;
        end else if (pay_off < frame_size) begin
          running_xor_next = running_xor ^ rx_byte;
          evt.wr_en        = (pay_off < 8'(PAYLOAD_BYTES));
        end
        // footer position check uses the size just seen
        end_hit = (byte_count >= POS_W'(3)) &&
                  ({1'b0, pos8} + 9'd1 == {1'b0, size_eff} + FRAME_OVERHEAD);
        if (end_hit) begin
          if (rx_byte == FTR0) begin
            state_next = S_FTR1;
          end else begin
            fail = 1'b1;
          end
        end else if ({1'b0, pos8} + 9'd1 >= 9'(MAX_FRAME_BYTES)) begin
          fail = 1'b1;
        end
      end
      S_FTR1: begin
        state_next      = S_HDR0;
        byte_count_next = '0;
        if (rx_byte == HDR1) begin
          if (frame_size != 8'(PAYLOAD_BYTES) || frame_checksum != running_xor) begin
            fail = 1'b1;
          end else begin
            ok                   = 1'b1;
            failure_latched_next = 1'b0;
          end
        end
      end
      default: begin
        state_next      = S_HDR0;
        byte_count_next = '0;
      end
    endcase
    // any failure returns to idle and latches
    if (fail) begin
      state_next           = S_HDR0;
      byte_count_next      = '0;
      failure_latched_next = 1'b1;
    end
    evt.fail = fail;
    evt.ok   = ok;
    evt.emit = fail || ok;
  end

  assign good_next = good_count + CNT_W'(ok);
  assign bad_next  = bad_count + CNT_W'(fail);

  // parse registers advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_HDR0;
      byte_count      <= '0;
      frame_checksum  <= '0;
      frame_size      <= '0;
      running_xor     <= '0;
      failure_latched <= 1'b0;
      good_count      <= '0;
      bad_count       <= '0;
    end else if (take) begin
      state           <= state_next;
      byte_count      <= byte_count_next;
      frame_checksum  <= frame_checksum_next;
      frame_size      <= frame_size_next;
      running_xor     <= running_xor_next;
      failure_latched <= failure_latched_next;
      good_count      <= good_next;
      bad_count       <= bad_next;
    end
  end

endmodule

>>> rtl/framed_packet_deframer_xor.sv
// top level of the framed packet deframer: parser, payload memory, drain and output register
// Takes one received byte per cycle and parses frames '%' '&' checksum size payload '^' '&',
// where checksum is the XOR of the payload. A good frame (size equal to PAYLOAD_BYTES,
// checksum matching) gives PAYLOAD_BYTES results, one per cycle while out_ready allows,
// read from the payload memory through its registered read port and an output register;
// the last one has last set. A bad frame gives one result with frame_ok low, unless
// its final footer byte is wrong, which drops it with no result; a run of junk before a
// header gives only one such notice. Every result carries the good and bad frame counts
// after the byte that caused it; both wrap at 32 bits. Bytes that cause no result, and
// payload bytes of the next frame that land in entries already drained, are taken every
// cycle while a payload burst drains. A byte that would cause a result waits until the
// burst and the output register are clear, and a payload byte for an entry not yet
// drained waits for that entry, so the input stalls at most while a good frame passes
// through the read stage into the output register, plus any stall on the output side.
module framed_packet_deframer_xor #(
  parameter int PAYLOAD_BYTES   = 32,
  parameter int MAX_FRAME_BYTES = 61
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                payload_byte,
  output logic [fpd_pkg::POS_W-1:0] byte_position,
  output logic                      last,
  output logic                      frame_ok,
  output logic [fpd_pkg::CNT_W-1:0] good_frames,
  output logic [fpd_pkg::CNT_W-1:0] bad_frames
);
  import fpd_pkg::*;

  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int DW = $clog2(PAYLOAD_BYTES + 1);

  parse_evt_t       evt;
  logic [CNT_W-1:0] good_next, bad_next;
  logic             take;

  logic [7:0]       payload_mem [PAYLOAD_BYTES];

  logic             drain_active;
  logic [DW-1:0]    drain_idx;
  logic [CNT_W-1:0] snap_good, snap_bad;
  logic             rd_valid;
  logic [AW-1:0]    rd_idx;
  logic [7:0]       rd_data;
  logic             rd_issue;
  logic             rd_move;
  logic             out_free;
  logic             drain_busy;
  logic             wr_block;
  logic             fail_load;

  fpd_parser #(
    .PAYLOAD_BYTES  (PAYLOAD_BYTES),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .rx_byte  (rx_byte),
    .evt      (evt),
    .good_next(good_next),
    .bad_next (bad_next)
  );

  // input flow control
  assign out_free   = !out_valid || out_ready;
  assign drain_busy = drain_active || rd_valid;
  assign wr_block   = evt.wr_en && drain_active &&
                      ({1'b0, evt.wr_idx} >= (POS_W + 1)'(drain_idx));
  assign in_ready   = !wr_block && (!evt.emit || (!drain_busy && out_free));
  assign take       = in_valid && in_ready;
  assign fail_load  = take && evt.fail;

  // payload memory write port
  always_ff @(posedge clk) begin
    if (take && evt.wr_en) begin
      payload_mem[evt.wr_idx[AW-1:0]] <= evt.wr_data;
    end
  end

  // drain read stage
  assign rd_move  = rd_valid && out_free;
  assign rd_issue = drain_active && (!rd_valid || rd_move);

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_data <= payload_mem[drain_idx[AW-1:0]];
      rd_idx  <= drain_idx[AW-1:0];
    end
  end

  // drain control
  always_ff @(posedge clk) begin
    if (rst) begin
      drain_active <= 1'b0;
      drain_idx    <= '0;
      rd_valid     <= 1'b0;
    end else begin
      if (take && evt.ok) begin
        drain_active <= 1'b1;
        drain_idx    <= '0;
      end else if (rd_issue) begin
        drain_idx <= drain_idx + DW'(1);
        if (drain_idx == DW'(PAYLOAD_BYTES - 1)) begin
          drain_active <= 1'b0;
        end
      end
      if (rd_issue) begin
        rd_valid <= 1'b1;
      end else if (rd_move) begin
        rd_valid <= 1'b0;
      end
    end
  end

  // counts seen by the burst of a good frame
  always_ff @(posedge clk) begin
    if (take && evt.ok) begin
      snap_good <= good_next;
      snap_bad  <= bad_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_move || fail_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (rd_move) begin
      payload_byte  <= rd_data;
      byte_position <= POS_W'(rd_idx);
      last          <= (rd_idx == AW'(PAYLOAD_BYTES - 1));
      frame_ok      <= 1'b1;
      good_frames   <= snap_good;
      bad_frames    <= snap_bad;
    end else if (fail_load) begin
      payload_byte  <= 8'd0;
      byte_position <= '0;
      last          <= 1'b1;
      frame_ok      <= 1'b0;
      good_frames   <= good_next;
      bad_frames    <= bad_next;
    end
  end

endmodule

>>> sim/framed_packet_deframer_xor_tb.sv
// self-checking testbench for the framed packet deframer with xor checksum
module framed_packet_deframer_xor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpd_pkg::*;

  localparam int PAYLOAD_BYTES   = 32;
  localparam int MAX_FRAME_BYTES = 61;
  // cycles to let a payload burst drain before the next step
  localparam int DRAIN_CYCLES    = 2 * PAYLOAD_BYTES + 8;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int RANDOM_BYTES    = 80;

  // one result as seen on the output ports
  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             ok;
    logic [CNT_W-1:0] good;
    logic [CNT_W-1:0] bad;
  } deframe_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           payload_byte;
  logic [POS_W-1:0]     byte_position;
  logic                 last;
  logic                 frame_ok;
  logic [CNT_W-1:0]     good_frames;
  logic [CNT_W-1:0]     bad_frames;

  // parser mirror
  parse_state_t         frm_state;
  logic [5:0]           frm_count;
  logic [7:0]           frm_checksum;
  logic [7:0]           frm_size;
  logic [7:0]           frm_xor;
  logic [7:0]           frm_payload [PAYLOAD_BYTES];
  logic                 frm_fail_latched;
  logic [CNT_W-1:0]     frm_good_count;
  logic [CNT_W-1:0]     frm_bad_count;

  deframe_result_t      pending_results [$];
  logic [7:0]           frame_buf [$];
  int                   mismatch_count = 0;
  int                   bytes_sent = 0;
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  int                   quiet_cycles = 0;

  framed_packet_deframer_xor #(
    .PAYLOAD_BYTES  (PAYLOAD_BYTES),
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .byte_position(byte_position),
    .last         (last),
    .frame_ok     (frame_ok),
    .good_frames  (good_frames),
    .bad_frames   (bad_frames)
  );

  always #10 clk = ~clk;

  // parser mirror: reset values
  function automatic void reset_deframer();
    frm_state        = S_HDR0;
    frm_count        = '0;
    frm_checksum     = '0;
    frm_size         = '0;
    frm_xor          = '0;
    frm_fail_latched = 1'b0;
    frm_good_count   = '0;
    frm_bad_count    = '0;
  endfunction

  // failure notice: counted, latched, back to header search
  function automatic void push_failure();
    deframe_result_t r;
    frm_bad_count    = frm_bad_count + 1;
    frm_fail_latched = 1'b1;
    frm_state        = S_HDR0;
    frm_count        = '0;
    r      = '0;
    r.last = 1'b1;
    r.good = frm_good_count;
    r.bad  = frm_bad_count;
    pending_results.push_back(r);
  endfunction

  // junk before a header gives a notice only once per run
  function automatic void take_junk();
    frm_state = S_HDR0;
    frm_count = '0;
    if (!frm_fail_latched) push_failure();
  endfunction

  // advance the parser mirror by one received byte, queue what it yields
  function automatic void deframe_byte(input logic [7:0] b);
    int pos;
    deframe_result_t r;
    case (frm_state)
      S_HDR0: begin
        if (b == HDR0) begin
          frm_count = 6'd1;
          frm_xor   = '0;
          frm_state = S_HDR1;
        end else begin
          take_junk();
        end
      end
      S_HDR1: begin
        if (b == HDR1) begin
          frm_count = 6'd2;
          frm_state = S_BODY;
        end else if (b != HDR0) begin
          take_junk();
        end
      end
      S_BODY: begin
        pos       = int'(frm_count);
        frm_count = frm_count + 6'd1;
        if (pos == 2) begin
          frm_checksum = b;
        end else if (pos == 3) begin
          frm_size = b;
        end else if (pos >= 4 && pos - 4 < int'(frm_size)) begin
          frm_xor = frm_xor ^ b;
          if (pos - 4 < PAYLOAD_BYTES) frm_payload[pos - 4] = b;
        end
        // footer position first, then the length limit
        if (pos + 1 > 3 && pos + 1 == int'(frm_size) + int'(FRAME_OVERHEAD)) begin
          if (b == FTR0) frm_state = S_FTR1;
          else push_failure();
        end else if (pos + 1 >= MAX_FRAME_BYTES) begin
          push_failure();
        end
      end
      S_FTR1: begin
        if (b != HDR1) begin
          frm_state = S_HDR0;
          frm_count = '0;
        end else if (int'(frm_size) != PAYLOAD_BYTES || frm_checksum != frm_xor) begin
          push_failure();
        end else begin
          frm_good_count   = frm_good_count + 1;
          frm_fail_latched = 1'b0;
          frm_state        = S_HDR0;
          frm_count        = '0;
          for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            r.data = frm_payload[i];
            r.pos  = POS_W'(i);
            r.last = (i == PAYLOAD_BYTES - 1);
            r.ok   = 1'b1;
            r.good = frm_good_count;
            r.bad  = frm_bad_count;
            pending_results.push_back(r);
          end
        end
      end
      default: begin
        frm_state = S_HDR0;
        frm_count = '0;
      end
    endcase
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // hold the input until every queued result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte_except(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == avoid);
    return b;
  endfunction

  // payload byte, now and then one of the delimiters or an extreme
  function automatic logic [7:0] body_byte();
    case ($urandom_range(15))
      0:       return HDR0;
      1:       return HDR1;
      2:       return FTR0;
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // frame into frame_buf; fill -1 random, -2 counting, else constant
  function automatic void build_frame(input int size_field, input int n_body,
                                      input bit bad_sum, input int fill);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    frame_buf = {HDR0, HDR1, 8'h00, 8'(size_field)};
    for (int i = 0; i < n_body; i++) begin
      if (fill == -1) b = body_byte();
      else if (fill == -2) b = 8'(i);
      else b = 8'(fill);
      if (i < size_field) sum = sum ^ b;
      frame_buf.push_back(b);
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    frame_buf[2] = sum;
    frame_buf.push_back(FTR0);
    frame_buf.push_back(HDR1);
  endfunction

  task automatic send_frame_buf();
    foreach (frame_buf[i]) send_byte(frame_buf[i]);
  endtask

  // good frames with extreme and patterned payloads, back to back
  task automatic test_good_frames();
    send_idle_pct = 0;
    stall_pct     = 0;
    build_frame(PAYLOAD_BYTES, PAYLOAD_BYTES, 1'b0, 8'hFF);
    send_frame_buf();
    build_frame(PAYLOAD_BYTES, PAYLOAD_BYTES, 1'b0, -2);
    send_frame_buf();
    wait_drained();
  endtask

  // junk runs, junk after the first header byte, repeated header byte
  task automatic test_header_junk();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR1);
    send_byte(HDR0);
    send_byte(8'h41);
    build_frame(PAYLOAD_BYTES, PAYLOAD_BYTES, 1'b0, -1);
    frame_buf.push_front(HDR0);
    frame_buf.push_front(HDR0);
    send_frame_buf();
    send_byte(HDR0);
    send_byte(FTR0);
    wait_drained();
  endtask

  // bad checksum, wrong size, missing or wrong footer, overlong frame
  task automatic test_frame_faults();
    stall_pct = 50;
    build_frame(PAYLOAD_BYTES, PAYLOAD_BYTES, 1'b1, -1);
    send_frame_buf();
    // latched failure: this junk gives no notice
    send_byte(8'h7F);
    build_frame(0, 0, 1'b0, -1);
    send_frame_buf();
    // footer start exactly at the frame limit
    build_frame(MAX_FRAME_BYTES - 5, MAX_FRAME_BYTES - 5, 1'b0, -1);
    send_frame_buf();
    // overlong: size beyond the frame limit, stream cut at the limit
    build_frame(255, MAX_FRAME_BYTES - 4, 1'b0, 8'hFF);
    void'(frame_buf.pop_back());
    void'(frame_buf.pop_back());
    send_frame_buf();
    // missing footer start
    build_frame(0, 0, 1'b0, -1);
    frame_buf[4] = HDR1;
    send_frame_buf();
    // wrong final footer drops the frame silently
    build_frame(0, 0, 1'b0, -1);
    frame_buf[frame_buf.size() - 1] = HDR0;
    send_frame_buf();
    wait_drained();
  endtask

  // one random sequence: mostly well-formed frames, some broken, some noise
  task automatic send_random_sequence();
    int kind;
    int sz;
    kind = $urandom_range(99);
    if (kind < 40) begin
      build_frame(PAYLOAD_BYTES, PAYLOAD_BYTES, 1'b0, -1);
    end else if (kind < 50) begin
      build_frame(PAYLOAD_BYTES, PAYLOAD_BYTES, 1'b1, -1);
    end else if (kind < 60) begin
      sz = $urandom_range(0, MAX_FRAME_BYTES - 6);
      if (sz >= PAYLOAD_BYTES) sz++;
      build_frame(sz, sz, bit'($urandom_range(1)), -1);
    end else if (kind < 68) begin
      sz = $urandom_range(0, 40);
      build_frame(sz, sz, 1'b0, -1);
      frame_buf[sz + 4] = pick_byte_except(FTR0);
    end else if (kind < 72) begin
      sz = $urandom_range(MAX_FRAME_BYTES - 4, 255);
      build_frame(sz, MAX_FRAME_BYTES - 4, 1'b0, -1);
      void'(frame_buf.pop_back());
      void'(frame_buf.pop_back());
    end else if (kind < 80) begin
      build_frame(PAYLOAD_BYTES, PAYLOAD_BYTES, 1'b0, -1);
      frame_buf[frame_buf.size() - 1] = pick_byte_except(HDR1);
    end else if (kind < 88) begin
      frame_buf = {};
      repeat ($urandom_range(1, 4)) frame_buf.push_back(pick_byte_except(HDR0));
    end else if (kind < 94) begin
      build_frame(PAYLOAD_BYTES, PAYLOAD_BYTES, 1'b0, -1);
      repeat ($urandom_range(1, 3)) frame_buf.push_front(HDR0);
    end else begin
      frame_buf = {};
      repeat ($urandom_range(1, 8)) frame_buf.push_back(body_byte());
    end
    send_frame_buf();
  endtask

  // random traffic over the idle and stall mixes
  task automatic test_random_traffic();
    int start;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 83; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES / 4) send_random_sequence();
      wait_drained();
    end
  endtask

  // receiver side stalls
  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // compare each output transfer with the oldest queued result
  always @(posedge clk) begin : check_results
    deframe_result_t got;
    deframe_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {payload_byte, byte_position, last, frame_ok, good_frames, bad_frames};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with none queued: data %h pos %0d last %b ok %b good %0d bad %0d",
                   $time, got.data, got.pos, got.last, got.ok, got.good, got.bad);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: expected data %h pos %0d last %b ok %b good %0d bad %0d",
                     $time, want.data, want.pos, want.last, want.ok, want.good, want.bad);
            $display("%0t: got      data %h pos %0d last %b ok %b good %0d bad %0d",
                     $time, got.data, got.pos, got.last, got.ok, got.good, got.bad);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_deframer();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_good_frames();
    test_header_junk();
    test_frame_faults();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
